// ===== sv/ins_sort_pkg.sv =====
package ins_sort_pkg;

    localparam int DEF_MAX_COUNT = 32;
    localparam int VALUE_W       = 31;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_NEGATIVE = 2'd1;
    localparam logic [1:0] ERR_CAPACITY = 2'd2;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic               set_end;
    } in_beat_t;

    typedef struct packed {
        logic [VALUE_W-1:0] sorted_value;
        logic               run_last;
        logic [1:0]         error_code;
    } out_beat_t;

    // controller -> datapath
    typedef struct packed {
        logic       insert;
        logic       shift;
        logic       load_data;
        logic       load_err;
        logic       data_last;
        logic [1:0] err_code;
    } cmd_t;

endpackage

// ===== sv/ins_sort_datapath.sv =====
module ins_sort_datapath #(
    parameter int MAX_COUNT = ins_sort_pkg::DEF_MAX_COUNT,
    parameter int CNT_W     = $clog2(MAX_COUNT + 1)
) (
    input  logic                              clk,
    input  ins_sort_pkg::cmd_t                cmd,
    input  logic [CNT_W-1:0]                  count,
    input  logic [ins_sort_pkg::VALUE_W-1:0]  value,
    output ins_sort_pkg::out_beat_t           result
);

    localparam int VW = ins_sort_pkg::VALUE_W;

    logic [VW-1:0]        cell_reg  [MAX_COUNT];
    logic [VW-1:0]        cell_next [MAX_COUNT];
    logic [VW-1:0]        cell_up   [MAX_COUNT];
    logic [VW-1:0]        cell_dn   [MAX_COUNT];
    logic [MAX_COUNT-1:0] gt;
    logic [MAX_COUNT-1:0] gt_up;
    ins_sort_pkg::out_beat_t result_reg;
    ins_sort_pkg::out_beat_t result_next;

    // Each cell compares against the incoming value; empty cells count as greater.
    // Strict compare puts the new value after equal entries.
    always_comb
    begin
        for (int i = 0; i < MAX_COUNT; i++)
        begin
            gt[i] = (CNT_W'(i) >= count) || (cell_reg[i] > value);
        end
        gt_up = {gt[MAX_COUNT-2:0], 1'b0};
        cell_up[0] = value;
        for (int i = 1; i < MAX_COUNT; i++)
        begin
            cell_up[i] = cell_reg[i-1];
        end
        for (int i = 0; i < MAX_COUNT - 1; i++)
        begin
            cell_dn[i] = cell_reg[i+1];
        end
        cell_dn[MAX_COUNT-1] = cell_reg[MAX_COUNT-1];
    end

    always_comb
    begin
        for (int i = 0; i < MAX_COUNT; i++)
        begin
            if (cmd.insert && gt[i])
            begin
                cell_next[i] = gt_up[i] ? cell_up[i] : value;
            end
            else if (cmd.shift)
            begin
                cell_next[i] = cell_dn[i];
            end
            else
            begin
                cell_next[i] = cell_reg[i];
            end
        end
    end

    always_comb
    begin
        result_next = result_reg;
        if (cmd.load_err)
        begin
            result_next.sorted_value = '0;
            result_next.run_last     = 1'b1;
            result_next.error_code   = cmd.err_code;
        end
        else if (cmd.load_data)
        begin
            result_next.sorted_value = cell_reg[0];
            result_next.run_last     = cmd.data_last;
            result_next.error_code   = ins_sort_pkg::ERR_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_COUNT; i++)
        begin
            cell_reg[i] <= cell_next[i];
        end
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

// ===== sv/ins_sort_ctrl.sv =====
module ins_sort_ctrl #(
    parameter int MAX_COUNT = ins_sort_pkg::DEF_MAX_COUNT,
    parameter int CNT_W     = $clog2(MAX_COUNT + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    sample_valid,
    output logic                    sample_ready,
    input  logic                    sample_neg,
    input  logic                    sample_end,
    output logic                    result_valid,
    input  logic                    result_ready,
    output ins_sort_pkg::cmd_t      cmd,
    output logic [CNT_W-1:0]        count
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic             state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;
    logic             accept;
    logic             full;

    assign out_free     = !out_valid_reg || result_ready;
    assign sample_ready = (state_reg == ST_IDLE) && out_free;
    assign accept       = sample_valid && sample_ready;
    assign full         = (fill_reg == CNT_W'(MAX_COUNT));

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg && !result_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (sample_neg || full)
                    begin
                        cmd.load_err   = 1'b1;
                        cmd.err_code   = sample_neg ? ins_sort_pkg::ERR_NEGATIVE
                                                    : ins_sort_pkg::ERR_CAPACITY;
                        fill_next      = '0;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        cmd.insert = 1'b1;
                        fill_next  = fill_reg + CNT_W'(1);
                        if (sample_end)
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                // fill_reg counts entries still to stream out of cell 0
                if (out_free)
                begin
                    cmd.load_data  = 1'b1;
                    cmd.shift      = 1'b1;
                    cmd.data_last  = (fill_reg == CNT_W'(1));
                    fill_next      = fill_reg - CNT_W'(1);
                    out_valid_next = 1'b1;
                    if (fill_reg == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                fill_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign count        = fill_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(MAX_COUNT))
        else $error("fill count above capacity");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> fill_reg != '0)
        else $error("emitting from an empty store");

    a_err_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_err |=> fill_reg == '0 && state_reg == ST_IDLE)
        else $error("error beat did not empty the store");

    a_end_starts_emit: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !sample_neg && !full && sample_end |=> state_reg == ST_EMIT)
        else $error("set end did not start the sorted run");

    a_no_load_over_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_err || cmd.load_data) |-> out_free)
        else $error("output register overwritten while beat pending");

endmodule

// ===== sv/insertion_sorter_core.sv =====
// Insertion sorter. Accepts non-negative values one beat per cycle, unless a held
// result stalls it, into a row of MAX_COUNT compare-and-shift cells; every cell
// compares against the incoming value in parallel, and equal values keep arrival
// order. The beat flagged set_end is inserted in its cycle, then the run streams
// out of cell 0 at one beat per cycle while result_ready is high, last beat marked
// run_last; no input is taken while the run streams. A negative value, or any value
// arriving with the store full, yields one error beat (value 0, run_last set) and
// empties the store. Results leave through an output register, so a new input is
// taken in the cycle the pending result is consumed.
module insertion_sorter_core #(
    parameter int MAX_COUNT = ins_sort_pkg::DEF_MAX_COUNT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    sample_valid,
    output logic                    sample_ready,
    input  ins_sort_pkg::in_beat_t  sample,
    output logic                    result_valid,
    input  logic                    result_ready,
    output ins_sort_pkg::out_beat_t result
);

    localparam int CNT_W = $clog2(MAX_COUNT + 1);

    ins_sort_pkg::cmd_t cmd;
    logic [CNT_W-1:0]   count;

    ins_sort_ctrl #(
        .MAX_COUNT (MAX_COUNT),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_neg   (sample.sample_value[31]),
        .sample_end   (sample.set_end),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd),
        .count        (count)
    );

    ins_sort_datapath #(
        .MAX_COUNT (MAX_COUNT),
        .CNT_W     (CNT_W)
    ) u_datapath (
        .clk    (clk),
        .cmd    (cmd),
        .count  (count),
        .value  (sample.sample_value[ins_sort_pkg::VALUE_W-1:0]),
        .result (result)
    );

endmodule
